// ----- rtl/uvs_pkg.sv -----
`default_nettype none
package uvs_pkg;

  localparam int MAX_DIVISIONS_DEF = 255;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STEPS      = 24;
  localparam int DIV_LANES         = 4;

  // CORDIC start vector length, the inverse of the 24-step gain in Q1.30.
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [1:0] {
    CFG_RADIUS      = 2'd0,
    CFG_SLICE_COUNT = 2'd1,
    CFG_STACK_COUNT = 2'd2
  } uvs_cfg_idx_t;

  typedef struct packed {
    logic [7:0] ring_index;
    logic [7:0] slice_index;
  } uvs_in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
  } uvs_out_t;

  typedef struct packed {
    logic top;
    logic bot;
  } uvs_pole_t;

  typedef struct packed {
    logic        top;
    logic        bot;
    logic [1:0]  quad_ph;
    logic [1:0]  quad_th;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
  } uvs_sb_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [31:0] z;
  } uvs_rot_t;

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
  } uvs_sc_t;

  // Arctangent of 2^-step in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] step);
    logic [31:0] a;
    case (step)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd1073741824) begin
      r = 32'sd1073741824;
    end else if (v < -34'sd1073741824) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Folds a first-quadrant rotation back into the quadrant of the phase.
  function automatic uvs_sc_t quad_map(input logic [1:0] q, input logic signed [31:0] x,
                                       input logic signed [31:0] y);
    uvs_sc_t r;
    case (q)
      2'd0: begin r.c = x;  r.s = y;  end
      2'd1: begin r.c = -y; r.s = x;  end
      2'd2: begin r.c = -x; r.s = -y; end
      default: begin r.c = y; r.s = -x; end
    endcase
    return r;
  endfunction

  // Q1.30 to Q2.14 with rounding half up, limited to plus or minus one.
  function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
    logic signed [32:0] s;
    logic signed [16:0] t;
    logic signed [15:0] r;
    s = {v[31], v} + 33'sd32768;
    t = s[32:16];
    if (t > 17'sd16384) begin
      r = 16'sd16384;
    end else if (t < -17'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = t[15:0];
    end
    return r;
  endfunction

  // Rounds a product with 30 fraction bits and saturates it to 32 bits.
  function automatic logic signed [31:0] sat_pos(input logic signed [63:0] p);
    logic signed [63:0] t;
    logic signed [31:0] r;
    t = (p + 64'sd536870912) >>> 30;
    if (t > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (t < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = t[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/uvs_div_cell.sv -----
`default_nettype none
module uvs_div_cell
  import uvs_pkg::*;
#(
  parameter int DW = 24
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          vld_i,
  input  wire logic [7:0]    den_i [DIV_LANES],
  input  wire logic [7:0]    rem_i [DIV_LANES],
  input  wire logic [DW-1:0] acc_i [DIV_LANES],
  input  wire uvs_pole_t     sb_i,
  output logic               vld_o,
  output logic [7:0]         rem_o [DIV_LANES],
  output logic [DW-1:0]      acc_o [DIV_LANES],
  output uvs_pole_t          sb_o
);

  logic          vld_r;
  logic [7:0]    rem_r   [DIV_LANES];
  logic [7:0]    rem_nxt [DIV_LANES];
  logic [DW-1:0] acc_r   [DIV_LANES];
  logic [DW-1:0] acc_nxt [DIV_LANES];
  uvs_pole_t     sb_r;

  // One restoring step per lane: bring down the next dividend bit and
  // subtract the divisor when it fits. Quotient bits fill in from the right.
  always_comb begin
    logic [8:0] t;
    logic       ge;
    for (int l = 0; l < DIV_LANES; l++) begin
      t  = {rem_i[l], acc_i[l][DW-1]};
      ge = (t >= {1'b0, den_i[l]});
      rem_nxt[l] = ge ? 8'(t - {1'b0, den_i[l]}) : t[7:0];
      acc_nxt[l] = {acc_i[l][DW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
      sb_r  <= sb_i;
    end
  end

  assign vld_o = vld_r;
  assign rem_o = rem_r;
  assign acc_o = acc_r;
  assign sb_o  = sb_r;

endmodule
`default_nettype wire

// ----- rtl/uvs_cordic_cell.sv -----
`default_nettype none
module uvs_cordic_cell
  import uvs_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     en,
  input  wire logic     vld_i,
  input  wire uvs_rot_t ph_i,
  input  wire uvs_rot_t th_i,
  input  wire uvs_sb_t  sb_i,
  output logic          vld_o,
  output uvs_rot_t      ph_o,
  output uvs_rot_t      th_o,
  output uvs_sb_t       sb_o
);

  localparam logic signed [31:0] ATAN = $signed(atan_turn(5'(STEP)));

  logic     vld_r;
  uvs_rot_t ph_r, ph_nxt;
  uvs_rot_t th_r, th_nxt;
  uvs_sb_t  sb_r;

  function automatic uvs_rot_t rotate(input uvs_rot_t a);
    uvs_rot_t          r;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    dx = a.y >>> STEP;
    dy = a.x >>> STEP;
    if (!a.z[31]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - ATAN;
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + ATAN;
    end
    return r;
  endfunction

  always_comb begin
    ph_nxt = rotate(ph_i);
    th_nxt = rotate(th_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r <= ph_nxt;
      th_r <= th_nxt;
      sb_r <= sb_i;
    end
  end

  assign vld_o = vld_r;
  assign ph_o  = ph_r;
  assign th_o  = th_r;
  assign sb_o  = sb_r;

endmodule
`default_nettype wire

// ----- rtl/uv_sphere_vertex_generator_core.sv -----
// Throughput: one request per cycle while the pipeline is not held; the chain of divider
// cells (one quotient bit each) and the chain of 24 CORDIC cells both move one vertex
// forward every cycle while the pipeline is not held.
// Reset (synchronous, rst_n low) empties the pipeline and loads radius 1.0,
// 20 slices and 20 stacks. The configuration port is always ready.
`default_nettype none
module uv_sphere_vertex_generator_core
  import uvs_pkg::*;
#(
  parameter int MAX_DIVISIONS = MAX_DIVISIONS_DEF,
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire uvs_in_t    in_req,
  output logic            out_valid,
  input  wire logic       out_ready,
  output uvs_out_t        out_rsp,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);

  // Dividend width: the index followed by the fraction bits of the widest quotient.
  localparam int DW = 8 + ((ANGLE_BITS > 15) ? ANGLE_BITS : 15);

  // Configuration registers. The user must change them only while the pipeline is empty;
  // the block itself does not enforce this, and every stage reads them directly.
  logic [30:0] radius_r;
  logic [7:0]  slice_count_r;
  logic [7:0]  stack_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r      <= 31'd65536;
      slice_count_r <= 8'd20;
      stack_count_r <= 8'd20;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RADIUS:      radius_r      <= cfg_data[30:0];
        CFG_SLICE_COUNT: slice_count_r <= cfg_data[7:0];
        CFG_STACK_COUNT: stack_count_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Effective counts after clamping to their legal ranges.
  logic [7:0] slices;
  logic [7:0] stacks;

  always_comb begin
    slices = (int'(slice_count_r) > MAX_DIVISIONS) ? 8'(MAX_DIVISIONS) : slice_count_r;
    if (slices < 8'd3) begin
      slices = 8'd3;
    end
    stacks = (int'(stack_count_r) > MAX_DIVISIONS) ? 8'(MAX_DIVISIONS) : stack_count_r;
    if (stacks < 8'd2) begin
      stacks = 8'd2;
    end
  end

  // The whole pipeline moves together. It holds only when the output register
  // is still waiting and the last stage has a vertex to hand over, so bubbles
  // keep draining and new requests keep coming in while a result waits.
  logic      adv;
  logic      vc_r;
  logic      out_valid_r;
  uvs_out_t  out_rsp_r;
  uvs_out_t  out_rsp_nxt;

  assign adv      = !(out_valid_r && !out_ready && vc_r);
  assign in_ready = adv;

  // Request front end: saturate the indices and form the four rounded
  // dividends (theta, phi, texture u, texture v).
  logic [7:0]    ring_s;
  logic [7:0]    slice_s;
  logic [7:0]    d_rem [DW+1][DIV_LANES];
  logic [DW-1:0] d_acc [DW+1][DIV_LANES];
  logic [7:0]    d_den [DIV_LANES];
  uvs_pole_t     d_sb  [DW+1];
  logic          d_vld [DW+1];

  always_comb begin
    ring_s  = (in_req.ring_index > stacks) ? stacks : in_req.ring_index;
    slice_s = (in_req.slice_index > slices) ? slices : in_req.slice_index;
    d_acc[0][0] = (DW'(slice_s) << ANGLE_BITS) + DW'(slices >> 1);
    d_acc[0][1] = (DW'(ring_s) << (ANGLE_BITS - 1)) + DW'(stacks >> 1);
    d_acc[0][2] = (DW'(slice_s) << 15) + DW'(slices >> 1);
    d_acc[0][3] = (DW'(ring_s) << 15) + DW'(stacks >> 1);
    for (int l = 0; l < DIV_LANES; l++) begin
      d_rem[0][l] = 8'd0;
    end
    d_den[0]   = slices;
    d_den[1]   = stacks;
    d_den[2]   = slices;
    d_den[3]   = stacks;
    d_sb[0].top = (ring_s == 8'd0);
    d_sb[0].bot = (ring_s == stacks);
    d_vld[0]    = in_valid;
  end

  // Pipelined restoring divider: each cell produces one quotient bit of all
  // four lanes.
  for (genvar k = 0; k < DW; k++) begin : g_div
    uvs_div_cell #(
      .DW(DW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .vld_i (d_vld[k]),
      .den_i (d_den),
      .rem_i (d_rem[k]),
      .acc_i (d_acc[k]),
      .sb_i  (d_sb[k]),
      .vld_o (d_vld[k+1]),
      .rem_o (d_rem[k+1]),
      .acc_o (d_acc[k+1]),
      .sb_o  (d_sb[k+1])
    );
  end

  // Angle codes become 32-bit phases. The top two bits select the quadrant
  // and the rest is the CORDIC target angle.
  logic [31:0] phase_th;
  logic [31:0] phase_ph;
  uvs_rot_t    c_ph  [CORDIC_STEPS+1];
  uvs_rot_t    c_th  [CORDIC_STEPS+1];
  uvs_sb_t     c_sb  [CORDIC_STEPS+1];
  logic        c_vld [CORDIC_STEPS+1];

  always_comb begin
    phase_th = 32'(d_acc[DW][0][ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
    phase_ph = 32'(d_acc[DW][1][ANGLE_BITS-1:0]) << (32 - ANGLE_BITS);
    c_th[0].x = CORDIC_GAIN;
    c_th[0].y = 34'sd0;
    c_th[0].z = {2'b00, phase_th[29:0]};
    c_ph[0].x = CORDIC_GAIN;
    c_ph[0].y = 34'sd0;
    c_ph[0].z = {2'b00, phase_ph[29:0]};
    c_sb[0].top     = d_sb[DW].top;
    c_sb[0].bot     = d_sb[DW].bot;
    c_sb[0].quad_ph = phase_ph[31:30];
    c_sb[0].quad_th = phase_th[31:30];
    c_sb[0].tex_u   = d_acc[DW][2][15:0];
    c_sb[0].tex_v   = d_acc[DW][3][15:0];
    c_vld[0]        = d_vld[DW];
  end

  // Two CORDIC lanes side by side, one rotation per cell.
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    uvs_cordic_cell #(
      .STEP(k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .vld_i (c_vld[k]),
      .ph_i  (c_ph[k]),
      .th_i  (c_th[k]),
      .sb_i  (c_sb[k]),
      .vld_o (c_vld[k+1]),
      .ph_o  (c_ph[k+1]),
      .th_o  (c_th[k+1]),
      .sb_o  (c_sb[k+1])
    );
  end

  // Stage A: limit the CORDIC outputs to plus or minus one and unfold the quadrant.
  uvs_sc_t sc_ph;
  uvs_sc_t sc_th;
  logic    va_r;
  uvs_sb_t sba_r;
  uvs_sc_t ph_a_r;
  uvs_sc_t th_a_r;

  assign sc_ph = quad_map(c_sb[CORDIC_STEPS].quad_ph, clamp_q30(c_ph[CORDIC_STEPS].x),
                          clamp_q30(c_ph[CORDIC_STEPS].y));
  assign sc_th = quad_map(c_sb[CORDIC_STEPS].quad_th, clamp_q30(c_th[CORDIC_STEPS].x),
                          clamp_q30(c_th[CORDIC_STEPS].y));

  // Stage B: unit direction x and z as sin(phi) times cos and sin of theta.
  logic signed [63:0] prod_x;
  logic signed [63:0] prod_z;
  logic               vb_r;
  uvs_sb_t            sbb_r;
  logic signed [31:0] ux_b_r;
  logic signed [31:0] uz_b_r;
  logic signed [31:0] cp_b_r;
  logic signed [31:0] st_b_r;
  logic signed [31:0] ct_b_r;

  assign prod_x = ph_a_r.s * th_a_r.c;
  assign prod_z = ph_a_r.s * th_a_r.s;

  // Stage C: scale by the radius and quantize normal and tangent.
  logic signed [31:0] rad_s;
  uvs_sb_t            sbc_r;
  logic signed [63:0] px_c_r;
  logic signed [63:0] py_c_r;
  logic signed [63:0] pz_c_r;
  logic signed [15:0] nx_c_r;
  logic signed [15:0] ny_c_r;
  logic signed [15:0] nz_c_r;
  logic signed [15:0] tx_c_r;
  logic signed [15:0] tz_c_r;

  assign rad_s = $signed({1'b0, radius_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else if (adv) begin
      va_r <= c_vld[CORDIC_STEPS];
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sba_r  <= c_sb[CORDIC_STEPS];
      ph_a_r <= sc_ph;
      th_a_r <= sc_th;

      sbb_r  <= sba_r;
      ux_b_r <= 32'((prod_x + 64'sd536870912) >>> 30);
      uz_b_r <= 32'((prod_z + 64'sd536870912) >>> 30);
      cp_b_r <= ph_a_r.c;
      st_b_r <= th_a_r.s;
      ct_b_r <= th_a_r.c;

      sbc_r  <= sbb_r;
      px_c_r <= rad_s * ux_b_r;
      py_c_r <= rad_s * cp_b_r;
      pz_c_r <= rad_s * uz_b_r;
      nx_c_r <= to_q14(ux_b_r);
      ny_c_r <= to_q14(cp_b_r);
      nz_c_r <= to_q14(uz_b_r);
      tx_c_r <= to_q14(-st_b_r);
      tz_c_r <= to_q14(ct_b_r);
    end
  end

  // Output stage: round and saturate the positions, and substitute the fixed
  // attributes at the two poles, where the slice has no effect.
  always_comb begin
    out_rsp_nxt.pos_x     = sat_pos(px_c_r);
    out_rsp_nxt.pos_y     = sat_pos(py_c_r);
    out_rsp_nxt.pos_z     = sat_pos(pz_c_r);
    out_rsp_nxt.normal_x  = nx_c_r;
    out_rsp_nxt.normal_y  = ny_c_r;
    out_rsp_nxt.normal_z  = nz_c_r;
    out_rsp_nxt.tangent_x = tx_c_r;
    out_rsp_nxt.tangent_y = 16'sd0;
    out_rsp_nxt.tangent_z = tz_c_r;
    out_rsp_nxt.tex_u     = sbc_r.tex_u;
    out_rsp_nxt.tex_v     = sbc_r.tex_v;
    if (sbc_r.top || sbc_r.bot) begin
      out_rsp_nxt.pos_x     = 32'sd0;
      out_rsp_nxt.pos_y     = sbc_r.top ? rad_s : -rad_s;
      out_rsp_nxt.pos_z     = 32'sd0;
      out_rsp_nxt.normal_x  = 16'sd0;
      out_rsp_nxt.normal_y  = sbc_r.top ? 16'sd16384 : -16'sd16384;
      out_rsp_nxt.normal_z  = 16'sd0;
      out_rsp_nxt.tangent_x = 16'sd16384;
      out_rsp_nxt.tangent_z = 16'sd0;
      out_rsp_nxt.tex_u     = 16'd0;
      out_rsp_nxt.tex_v     = sbc_r.top ? 16'd0 : 16'd32768;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && vc_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && vc_r) begin
      out_rsp_r <= out_rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
`default_nettype wire

// ----- rtl/uvs_chk.sv -----
`default_nettype none
module uvs_chk
  import uvs_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire uvs_in_t     in_req,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire uvs_out_t    out_rsp,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [1:0]  cfg_index,
  input wire logic [31:0] cfg_data
);

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rsp))
    else $error("result changed while stalled");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  // The tangent never leaves the horizontal plane.
  a_tangent_flat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.tangent_y == 16'sd0)
    else $error("tangent has a vertical part");

  // Texture coordinates and the vertical normal stay within one.
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.tex_u <= 16'd32768 && out_rsp.tex_v <= 16'd32768
                  && out_rsp.normal_y <= 16'sd16384 && out_rsp.normal_y >= -16'sd16384)
    else $error("unit quantity out of range");

endmodule

bind uv_sphere_vertex_generator_core uvs_chk u_uvs_chk (.*);
`default_nettype wire
